FILE: hw/rtl/lcdws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdws_pkg
// Types and constants shared by the character-LCD write sequencer modules.
// ----------------------------------------------------------------------------
package lcdws_pkg;

    typedef enum logic [2:0] {
        ACT_INIT   = 3'd0,
        ACT_DATA   = 3'd1,
        ACT_CMD    = 3'd2,
        ACT_CLEAR  = 3'd3,
        ACT_CURSOR = 3'd4,
        ACT_NUMBER = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        POS_KEEP  = 2'd0,
        POS_CLEAR = 2'd1,
        POS_LOAD  = 2'd2
    } t_pos_op;

    // One decoded request: up to four bytes, sent from index first to 3,
    // or the fixed power-on sequence when is_init is set.
    typedef struct packed {
        logic            is_init;
        logic            rs;
        logic [1:0]      first;
        logic [3:0][7:0] bytes;
        logic [13:0]     settle;
        t_pos_op         pos_op;
        logic [7:0]      new_pos;
    } t_cmd;

    typedef struct packed {
        logic [3:0]  nibble;
        logic [15:0] wait_us;
    } t_init_step;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned INIT_STEPS  = 12;

    localparam logic [15:0] BYTE_WAIT_US  = 16'd50;
    localparam logic [15:0] ROW_WAIT_US   = 16'd2000;
    localparam logic [13:0] INIT_SETTLE   = 14'd13000;
    localparam logic [13:0] CLEAR_SETTLE  = 14'd2000;
    localparam logic [7:0]  CMD_CLEAR     = 8'h01;
    localparam logic [7:0]  CMD_SET_DDRAM = 8'h80;
    localparam logic [7:0]  ASCII_ZERO    = 8'h30;

    localparam logic [3:0][7:0] ROW_OFFSET = {8'h54, 8'h14, 8'h40, 8'h00};

    // Power-on sequence: three wake-ups, 4-bit switch, then 0x28 0x08 0x01 0x0C
    localparam t_init_step INIT_SEQ [INIT_STEPS] = '{
        '{4'h3, 16'd50000},
        '{4'h3, 16'd5000},
        '{4'h3, 16'd5000},
        '{4'h2, 16'd5000},
        '{4'h2, 16'd50},
        '{4'h8, 16'd0},
        '{4'h0, 16'd5050},
        '{4'h8, 16'd0},
        '{4'h0, 16'd13050},
        '{4'h1, 16'd0},
        '{4'h0, 16'd13050},
        '{4'hC, 16'd0}
    };

endpackage

FILE: hw/rtl/lcdws_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdws_front
// Accepts requests, splits numbers into decimal digits and builds the byte
// list for each request. Two register stages, the whole pipe stalls together.
// ----------------------------------------------------------------------------
module lcdws_front #(
    parameter int LINE_LENGTH = 16,
    parameter int ROW_COUNT   = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [2:0]        i_action,
    input  logic [7:0]        i_value,
    input  logic [5:0]        i_column,
    input  logic [1:0]        i_row,
    input  logic [13:0]       i_number,
    input  logic [2:0]        i_digits,
    output logic              o_push,
    output lcdws_pkg::t_cmd   o_cmd,
    input  logic              i_queue_ready
);
    import lcdws_pkg::*;

    localparam logic [2:0] ROW_LIMIT = 3'(ROW_COUNT);
    localparam logic [1:0] ROW_MAX   = 2'(ROW_COUNT - 1);
    localparam logic [7:0] LINE_LEN8 = 8'(LINE_LENGTH);
    // 2^24 / 1000 rounded up: exact quotient for any 14-bit value
    localparam logic [28:0] RECIP_1000 = 29'd16778;

    function automatic logic [11:0] f_to_bcd(input logic [9:0] bin);
        logic [11:0] bcd;
        bcd = '0;
        for (int i = 9; i >= 0; i--) begin
            for (int d = 0; d < 3; d++) begin
                if (bcd[4*d +: 4] >= 4'd5) begin
                    bcd[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
                end
            end
            bcd = {bcd[10:0], bin[i]};
        end
        return bcd;
    endfunction

    logic        r_a_valid, r_b_valid;
    logic [2:0]  r_a_action, r_b_action;
    logic [7:0]  r_a_value, r_b_value;
    logic [5:0]  r_a_column, r_b_column;
    logic [1:0]  r_a_row, r_b_row;
    logic [2:0]  r_a_digits, r_b_digits;
    logic [13:0] r_a_number;
    logic [4:0]  r_a_th, r_b_th;
    logic [9:0]  r_b_rem;

    logic        w_en, w_need_push, w_known;
    logic [28:0] w_prod;
    logic [13:0] w_th_k, w_rem;
    logic [11:0] w_bcd;
    logic [1:0]  w_row_c;
    t_cmd        w_cmd;

    assign w_prod = {15'd0, i_number} * RECIP_1000;
    assign w_th_k = {9'd0, r_a_th} * 14'd1000;
    assign w_rem  = r_a_number - w_th_k;

    assign w_known     = (r_b_action <= 3'(ACT_NUMBER));
    assign w_need_push = r_b_valid && w_known;
    assign w_en        = !w_need_push || i_queue_ready;
    assign o_ready     = w_en;
    assign o_push      = w_need_push && i_queue_ready;
    assign o_cmd       = w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else if (w_en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_action <= i_action;
            r_a_value  <= i_value;
            r_a_column <= i_column;
            r_a_row    <= i_row;
            r_a_digits <= i_digits;
            r_a_number <= i_number;
            r_a_th     <= w_prod[28:24];
            r_b_action <= r_a_action;
            r_b_value  <= r_a_value;
            r_b_column <= r_a_column;
            r_b_row    <= r_a_row;
            r_b_digits <= r_a_digits;
            r_b_th     <= r_a_th;
            r_b_rem    <= w_rem[9:0];
        end
    end

    assign w_bcd   = f_to_bcd(r_b_rem);
    assign w_row_c = ({1'b0, r_b_row} >= ROW_LIMIT) ? ROW_MAX : r_b_row;

    always_comb begin
        w_cmd          = '0;
        w_cmd.first    = 2'd3;
        w_cmd.pos_op   = POS_KEEP;
        unique case (t_action'(r_b_action))
            ACT_INIT: begin
                w_cmd.is_init = 1'b1;
                w_cmd.settle  = INIT_SETTLE;
                w_cmd.pos_op  = POS_CLEAR;
            end
            ACT_DATA: begin
                w_cmd.rs       = 1'b1;
                w_cmd.bytes[3] = r_b_value;
            end
            ACT_CMD: begin
                w_cmd.bytes[3] = r_b_value;
            end
            ACT_CLEAR: begin
                w_cmd.bytes[3] = CMD_CLEAR;
                w_cmd.settle   = CLEAR_SETTLE;
                w_cmd.pos_op   = POS_CLEAR;
            end
            ACT_CURSOR: begin
                w_cmd.bytes[3] = CMD_SET_DDRAM
                               | (8'(r_b_column) + ROW_OFFSET[w_row_c]);
                w_cmd.new_pos  = ({6'd0, w_row_c} * LINE_LEN8) + 8'(r_b_column);
                w_cmd.pos_op   = POS_LOAD;
            end
            ACT_NUMBER: begin
                w_cmd.rs       = 1'b1;
                w_cmd.bytes[0] = ASCII_ZERO + {3'd0, r_b_th};
                w_cmd.bytes[1] = ASCII_ZERO + {4'd0, w_bcd[11:8]};
                w_cmd.bytes[2] = ASCII_ZERO + {4'd0, w_bcd[7:4]};
                w_cmd.bytes[3] = ASCII_ZERO + {4'd0, w_bcd[3:0]};
                if (r_b_digits >= 3'd4) begin
                    w_cmd.first = 2'd0;
                end else if (r_b_digits == 3'd3) begin
                    w_cmd.first = 2'd1;
                end else if (r_b_digits == 3'd2) begin
                    w_cmd.first = 2'd2;
                end else begin
                    w_cmd.first = 2'd3;
                end
            end
            default: begin
                w_cmd = '0;
            end
        endcase
    end

endmodule

FILE: hw/rtl/lcdws_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdws_queue
// Short FIFO of decoded requests between the front and back ends.
// ----------------------------------------------------------------------------
module lcdws_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lcdws_pkg::t_cmd   i_cmd,
    output logic              o_ready,
    input  logic              i_pop,
    output logic              o_valid,
    output lcdws_pkg::t_cmd   o_cmd
);
    import lcdws_pkg::*;

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam logic [PTR_W:0] FULL_COUNT = (PTR_W + 1)'(QUEUE_DEPTH);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [PTR_W:0]   r_count;
    logic             w_push, w_pop;

    assign o_ready = (r_count != FULL_COUNT);
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

FILE: hw/rtl/lcdws_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdws_back
// Expands the request at the queue head into nibble strobes, one per cycle
// while not stalled, and keeps the character position for line-change waits.
// ----------------------------------------------------------------------------
module lcdws_back #(
    parameter int LINE_LENGTH = 16,
    parameter int ROW_COUNT   = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  lcdws_pkg::t_cmd   i_cmd,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [3:0]        o_nibble,
    output logic              o_rs,
    output logic [15:0]       o_wait_us,
    output logic [13:0]       o_settle_us,
    output logic              o_last
);
    import lcdws_pkg::*;

    localparam logic [7:0] TOTAL_CHARS = 8'(LINE_LENGTH * ROW_COUNT);
    localparam logic [3:0] INIT_LAST   = 4'(INIT_STEPS - 1);
    localparam logic [3:0] BYTES_LAST  = 4'd7;

    logic        r_valid, r_last, r_rs;
    logic [3:0]  r_nibble;
    logic [15:0] r_wait;
    logic [13:0] r_settle;
    logic [3:0]  r_cnt;
    logic [7:0]  r_pos;

    logic        w_load, w_fire, w_hi, w_last, w_row_wait;
    logic [3:0]  w_idx, w_nibble;
    logic [7:0]  w_byte, n_pos;
    logic [15:0] w_wait;

    assign w_load = !r_valid || i_ready;
    assign w_fire = w_load && i_valid;
    assign o_pop  = w_fire && w_last;

    assign w_idx  = {1'b0, i_cmd.first, 1'b0} + r_cnt;
    assign w_byte = i_cmd.bytes[w_idx[2:1]];
    assign w_hi   = !w_idx[0];

    // line change: at the end of the display, or at the start of a later row
    always_comb begin
        w_row_wait = (r_pos == TOTAL_CHARS);
        for (int k = 1; k < ROW_COUNT; k++) begin
            if (r_pos == 8'(k * LINE_LENGTH)) begin
                w_row_wait = 1'b1;
            end
        end
    end

    always_comb begin
        if (i_cmd.is_init) begin
            w_nibble = INIT_SEQ[r_cnt].nibble;
            w_wait   = INIT_SEQ[r_cnt].wait_us;
            w_last   = (r_cnt == INIT_LAST);
        end else begin
            w_nibble = w_hi ? w_byte[7:4] : w_byte[3:0];
            w_last   = (w_idx == BYTES_LAST);
            if (!w_hi) begin
                w_wait = '0;
            end else if (i_cmd.rs && w_row_wait) begin
                w_wait = BYTE_WAIT_US + ROW_WAIT_US;
            end else begin
                w_wait = BYTE_WAIT_US;
            end
        end
    end

    always_comb begin
        n_pos = r_pos;
        if (w_fire && !i_cmd.is_init && i_cmd.rs && w_hi) begin
            n_pos = (r_pos == TOTAL_CHARS) ? 8'd1 : r_pos + 8'd1;
        end
        if (o_pop) begin
            case (i_cmd.pos_op)
                POS_CLEAR: n_pos = '0;
                POS_LOAD:  n_pos = i_cmd.new_pos;
                default:   n_pos = n_pos;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= '0;
            r_pos   <= '0;
        end else begin
            r_pos <= n_pos;
            if (w_load) begin
                r_valid <= i_valid;
            end
            if (w_fire) begin
                r_cnt <= w_last ? 4'd0 : r_cnt + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_nibble <= w_nibble;
            r_rs     <= i_cmd.rs;
            r_wait   <= w_wait;
            r_settle <= w_last ? i_cmd.settle : '0;
            r_last   <= w_last;
        end
    end

    assign o_valid     = r_valid;
    assign o_nibble    = r_nibble;
    assign o_rs        = r_rs;
    assign o_wait_us   = r_wait;
    assign o_settle_us = r_settle;
    assign o_last      = r_last;

endmodule

FILE: hw/rtl/char_lcd_4bit_write_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_4bit_write_sequencer
// Turns character-LCD requests into 4-bit enable strobes with their waits.
//
//   channel   dir  handshake                      payload
//   s_axis    in   i_s_axis_tvalid/o_s_axis_tready tuser action, tdata fields
//   m_axis    out  o_m_axis_tvalid/i_m_axis_tready one strobe, tlast per request
//
// One strobe leaves per cycle from the output register while the output is
// ready: 2 per byte, up to 8 for a number and 12 for init. Requests enter
// back to back unless the front stalls; each passes the front's a and b
// registers, and a four-deep queue lets it run ahead of the strobe generator.
// Synchronous active-low reset clears the handshake state and the position.
// ----------------------------------------------------------------------------
module char_lcd_4bit_write_sequencer #(
    parameter int LINE_LENGTH = 16,
    parameter int ROW_COUNT   = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // value[7:0], column[13:8], row[15:14], number[29:16], digits[32:30]
    input  logic [39:0] i_s_axis_tdata,
    // action[2:0]
    input  logic [2:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // nibble[3:0], wait_before_us[19:4], settle_after_us[33:20]
    output logic [39:0] o_m_axis_tdata,
    // register_select[0]
    output logic [0:0]  o_m_axis_tuser,
    output logic        o_m_axis_tlast
);
    import lcdws_pkg::*;

    t_cmd        w_push_cmd, w_head_cmd;
    logic        w_push, w_queue_ready, w_head_valid, w_pop;
    logic [3:0]  w_nibble;
    logic [15:0] w_wait;
    logic [13:0] w_settle;

    lcdws_front #(
        .LINE_LENGTH (LINE_LENGTH),
        .ROW_COUNT   (ROW_COUNT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_s_axis_tvalid),
        .o_ready       (o_s_axis_tready),
        .i_action      (i_s_axis_tuser),
        .i_value       (i_s_axis_tdata[7:0]),
        .i_column      (i_s_axis_tdata[13:8]),
        .i_row         (i_s_axis_tdata[15:14]),
        .i_number      (i_s_axis_tdata[29:16]),
        .i_digits      (i_s_axis_tdata[32:30]),
        .o_push        (w_push),
        .o_cmd         (w_push_cmd),
        .i_queue_ready (w_queue_ready)
    );

    lcdws_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_ready (w_queue_ready),
        .i_pop   (w_pop),
        .o_valid (w_head_valid),
        .o_cmd   (w_head_cmd)
    );

    lcdws_back #(
        .LINE_LENGTH (LINE_LENGTH),
        .ROW_COUNT   (ROW_COUNT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_head_valid),
        .i_cmd       (w_head_cmd),
        .o_pop       (w_pop),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_nibble    (w_nibble),
        .o_rs        (o_m_axis_tuser[0]),
        .o_wait_us   (w_wait),
        .o_settle_us (w_settle),
        .o_last      (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {6'd0, w_settle, w_wait, w_nibble};

endmodule

FILE: tb/tb_char_lcd_4bit_write_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_char_lcd_4bit_write_sequencer
// Self-checking bench for the 4-bit character-LCD write sequencer. Requests
// are driven on the input stream and every strobe word leaving the block is
// compared field by field with a local model of the sequencer. The model
// tracks the character position and works out nibbles, register select,
// waits and settle times. Directed cases come first, then a long output
// hold-off, random traffic with bursty idling on both sides and a quiet tail.
// ----------------------------------------------------------------------------
module tb_char_lcd_4bit_write_sequencer;
    import lcdws_pkg::*;

    localparam int          LINE_LEN      = 16;
    localparam int          ROWS          = 2;
    localparam int unsigned SCREEN_CHARS  = LINE_LEN * ROWS;
    localparam int          CYCLE_LIMIT   = 250000;
    localparam int          END_CYCLES    = 20;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          MAIN_ITEMS    = 230;
    localparam int          TAIL_ITEMS    = 70;

    // action codes the block does not decode
    localparam logic [2:0]  ACT_RSVD_A    = 3'd6;
    localparam logic [2:0]  ACT_RSVD_B    = 3'd7;

    localparam logic [3:0]  NIB_WAKE      = 4'h3;
    localparam logic [3:0]  NIB_4BIT      = 4'h2;
    localparam logic [7:0]  CMD_FUNC_SET  = 8'h28;
    localparam logic [7:0]  CMD_DISP_OFF  = 8'h08;
    localparam logic [7:0]  CMD_DISP_ON   = 8'h0C;
    localparam int unsigned POWER_UP_US   = 50000;
    localparam int unsigned WAKE_GAP_US   = 5000;
    localparam int unsigned SLOW_CMD_US   = 13000;

    typedef struct {
        logic [3:0]  nibble;
        logic        rs;
        logic [15:0] wait_us;
        logic [13:0] settle_us;
        logic        is_last;
    } t_strobe;

    class lcd_strobe_scoreboard;
        t_strobe    expected_q[$];
        t_strobe    request_q[$];
        logic [7:0] char_pos;
        int         errors;

        function new();
            char_pos = '0;
            errors   = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t ns: %s", $time, msg);
            errors++;
        endtask

        function void add_nibble(logic [3:0] nib, logic rs, int unsigned wait_us);
            t_strobe s;
            s.nibble    = nib;
            s.rs        = rs;
            s.wait_us   = 16'(wait_us);
            s.settle_us = '0;
            s.is_last   = 1'b0;
            request_q.push_back(s);
        endfunction

        // data bytes move the cursor and pay the row-change wait
        function void add_byte(logic rs, logic [7:0] b, int unsigned extra_us);
            int unsigned w;
            int unsigned p;
            w = extra_us + BYTE_WAIT_US;
            if (rs) begin
                p = char_pos;
                if (p == SCREEN_CHARS) begin
                    char_pos = '0;
                    w += ROW_WAIT_US;
                end else if (p != 0 && p < SCREEN_CHARS && (p % LINE_LEN) == 0) begin
                    w += ROW_WAIT_US;
                end
                char_pos = char_pos + 8'd1;
            end
            add_nibble(b[7:4], rs, w);
            add_nibble(b[3:0], rs, 0);
        endfunction

        function void close_request(int unsigned settle_us);
            int n;
            n = request_q.size();
            if (n > 0) begin
                request_q[n-1].settle_us = 14'(settle_us);
                request_q[n-1].is_last   = 1'b1;
            end
            foreach (request_q[i]) expected_q.push_back(request_q[i]);
            request_q.delete();
        endfunction

        task note_request(logic [2:0] act, logic [7:0] value, logic [5:0] col,
                          logic [1:0] row, logic [13:0] num, logic [2:0] dig);
            int unsigned r;
            int unsigned th, rem, hu, te, on;
            logic [7:0]  cmd;
            case (act)
                ACT_INIT: begin
                    char_pos = '0;
                    add_nibble(NIB_WAKE, 1'b0, POWER_UP_US);
                    add_nibble(NIB_WAKE, 1'b0, WAKE_GAP_US);
                    add_nibble(NIB_WAKE, 1'b0, WAKE_GAP_US);
                    add_nibble(NIB_4BIT, 1'b0, WAKE_GAP_US);
                    add_byte(1'b0, CMD_FUNC_SET, 0);
                    add_byte(1'b0, CMD_DISP_OFF, WAKE_GAP_US);
                    add_byte(1'b0, CMD_CLEAR, SLOW_CMD_US);
                    add_byte(1'b0, CMD_DISP_ON, SLOW_CMD_US);
                    close_request(INIT_SETTLE);
                end
                ACT_DATA: begin
                    add_byte(1'b1, value, 0);
                    close_request(0);
                end
                ACT_CMD: begin
                    add_byte(1'b0, value, 0);
                    close_request(0);
                end
                ACT_CLEAR: begin
                    add_byte(1'b0, CMD_CLEAR, 0);
                    char_pos = '0;
                    close_request(CLEAR_SETTLE);
                end
                ACT_CURSOR: begin
                    r        = (row >= ROWS) ? ROWS - 1 : row;
                    char_pos = 8'(r * LINE_LEN + col);
                    cmd      = 8'(CMD_SET_DDRAM | (col + ROW_OFFSET[r]));
                    add_byte(1'b0, cmd, 0);
                    close_request(0);
                end
                ACT_NUMBER: begin
                    th  = num / 1000;
                    rem = num - th * 1000;
                    hu  = rem / 100;
                    te  = (rem - hu * 100) / 10;
                    on  = rem - hu * 100 - te * 10;
                    // over-range thousands go out as a non-digit character
                    if (dig > 3) add_byte(1'b1, 8'(ASCII_ZERO + th), 0);
                    if (dig > 2) add_byte(1'b1, 8'(ASCII_ZERO + hu), 0);
                    if (dig > 1) add_byte(1'b1, 8'(ASCII_ZERO + te), 0);
                    add_byte(1'b1, 8'(ASCII_ZERO + on), 0);
                    close_request(0);
                end
                default: ;
            endcase
        endtask

        task check_strobe(logic [3:0] nib, logic rs, logic [15:0] wait_us,
                          logic [13:0] settle_us, logic is_last);
            t_strobe e;
            if (expected_q.size() == 0) begin
                report($sformatf("strobe with nothing expected: nibble %h rs %b", nib, rs));
                return;
            end
            e = expected_q.pop_front();
            if (nib !== e.nibble)
                report($sformatf("nibble %h, expected %h", nib, e.nibble));
            if (rs !== e.rs)
                report($sformatf("register select %b, expected %b", rs, e.rs));
            if (wait_us !== e.wait_us)
                report($sformatf("wait %0d us, expected %0d", wait_us, e.wait_us));
            if (settle_us !== e.settle_us)
                report($sformatf("settle %0d us, expected %0d", settle_us, e.settle_us));
            if (is_last !== e.is_last)
                report($sformatf("tlast %b, expected %b", is_last, e.is_last));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [39:0] i_s_axis_tdata;
    logic [2:0]  i_s_axis_tuser;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [39:0] o_m_axis_tdata;
    logic [0:0]  o_m_axis_tuser;
    logic        o_m_axis_tlast;

    lcd_strobe_scoreboard sb = new();

    bit rx_idle_en;
    bit tx_idle_en;
    int rx_hold_len;
    int cycle_count = 0;

    char_lcd_4bit_write_sequencer #(
        .LINE_LENGTH (LINE_LEN),
        .ROW_COUNT   (ROWS)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** char_lcd_4bit_write_sequencer: FAILED **");
            $finish;
        end
    end

    // both words are checked on the edge that moves them
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                sb.note_request(i_s_axis_tuser, i_s_axis_tdata[7:0],
                                i_s_axis_tdata[13:8], i_s_axis_tdata[15:14],
                                i_s_axis_tdata[29:16], i_s_axis_tdata[32:30]);
            if (o_m_axis_tvalid && i_m_axis_tready)
                sb.check_strobe(o_m_axis_tdata[3:0], o_m_axis_tuser[0],
                                o_m_axis_tdata[19:4], o_m_axis_tdata[33:20],
                                o_m_axis_tlast);
        end
    end

    // output back-pressure: short random bursts, or one long hold on request
    always begin : rx_ready_drive
        int gap;
        @(negedge i_clk);
        if (rx_hold_len > 0) begin
            i_m_axis_tready = 1'b0;
            for (int c = 0; c < rx_hold_len; c++) @(negedge i_clk);
            rx_hold_len     = 0;
            i_m_axis_tready = 1'b1;
        end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
            gap             = $urandom_range(1, 4);
            i_m_axis_tready = 1'b0;
            repeat (gap) @(negedge i_clk);
            i_m_axis_tready = 1'b1;
        end else begin
            i_m_axis_tready = 1'b1;
        end
    end

    task automatic send_request(logic [2:0] act, logic [7:0] value, logic [5:0] col,
                                logic [1:0] row, logic [13:0] num, logic [2:0] dig);
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tuser  = act;
        i_s_axis_tdata  = {7'd0, dig, num, row, col, value};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    task automatic sender_gap(int n);
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    task automatic maybe_gap();
        if (tx_idle_en && $urandom_range(0, 3) == 0)
            sender_gap($urandom_range(1, 4));
    endtask

    task automatic wait_drained();
        sender_gap(1);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic send_random_request(output bit counted);
        int          pick;
        logic [2:0]  act;
        logic [13:0] num;
        logic [5:0]  col;
        pick = $urandom_range(0, 99);
        if (pick < 34)      act = ACT_DATA;
        else if (pick < 58) act = ACT_NUMBER;
        else if (pick < 70) act = ACT_CURSOR;
        else if (pick < 80) act = ACT_CMD;
        else if (pick < 87) act = ACT_CLEAR;
        else if (pick < 92) act = ACT_INIT;
        else                act = $urandom_range(0, 1) ? ACT_RSVD_A : ACT_RSVD_B;
        num = ($urandom_range(0, 4) != 0) ? 14'($urandom_range(0, 9999))
                                          : 14'($urandom_range(0, 16383));
        col = ($urandom_range(0, 3) != 0) ? 6'($urandom_range(0, 39))
                                          : 6'($urandom_range(0, 63));
        send_request(act, 8'($urandom_range(0, 255)), col, 2'($urandom_range(0, 3)),
                     num, 3'($urandom_range(0, 7)));
        counted = (act != ACT_RSVD_A) && (act != ACT_RSVD_B);
    endtask

    task automatic random_phase(int n_items);
        int items;
        int run;
        bit counted;
        items = 0;
        while (items < n_items) begin
            if ($urandom_range(0, 29) == 0) begin
                // plain text run long enough to cross line boundaries
                run = $urandom_range(16, 40);
                repeat (run) begin
                    maybe_gap();
                    send_request(ACT_DATA, 8'($urandom_range(0, 255)), '0, '0, '0, '0);
                end
                items += run;
            end else begin
                maybe_gap();
                send_random_request(counted);
                if (counted) items++;
            end
        end
    endtask

    initial begin
        bit counted;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = ACT_INIT;
        i_m_axis_tready = 1'b0;
        rx_idle_en      = 1'b1;
        tx_idle_en      = 1'b1;
        rx_hold_len     = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes, every action, clamps, line crossings, wrap
        send_request(ACT_INIT,   8'h00, 6'd0,  2'd0, 14'd0,     3'd0);
        send_request(ACT_DATA,   8'h00, 6'd0,  2'd0, 14'd0,     3'd0);
        send_request(ACT_DATA,   8'hFF, 6'd63, 2'd3, 14'h3FFF,  3'd7);
        send_request(ACT_CMD,    8'h00, 6'd0,  2'd0, 14'd0,     3'd0);
        send_request(ACT_CMD,    8'hFF, 6'd0,  2'd0, 14'd0,     3'd0);
        send_request(ACT_CLEAR,  8'h00, 6'd0,  2'd0, 14'd0,     3'd0);
        send_request(ACT_CURSOR, 8'h00, 6'd39, 2'd1, 14'd0,     3'd0);
        send_request(ACT_DATA,   8'h41, 6'd0,  2'd0, 14'd0,     3'd0);
        send_request(ACT_CURSOR, 8'h00, 6'd5,  2'd2, 14'd0,     3'd0);
        send_request(ACT_CURSOR, 8'h00, 6'd63, 2'd3, 14'd0,     3'd0);
        send_request(ACT_CURSOR, 8'h00, 6'd14, 2'd0, 14'd0,     3'd0);
        send_request(ACT_NUMBER, 8'h00, 6'd0,  2'd0, 14'd9999,  3'd4);
        send_request(ACT_CURSOR, 8'h00, 6'd14, 2'd1, 14'd0,     3'd0);
        send_request(ACT_NUMBER, 8'h00, 6'd0,  2'd0, 14'h3FFF,  3'd7);
        send_request(ACT_NUMBER, 8'h00, 6'd0,  2'd0, 14'd0,     3'd0);
        send_request(ACT_NUMBER, 8'h00, 6'd0,  2'd0, 14'd1234,  3'd2);
        send_request(ACT_NUMBER, 8'h00, 6'd0,  2'd0, 14'd507,   3'd3);
        send_request(ACT_RSVD_A, 8'hA5, 6'd7,  2'd1, 14'd77,    3'd4);
        send_request(ACT_RSVD_B, 8'h5A, 6'd9,  2'd2, 14'd88,    3'd1);
        send_request(ACT_CLEAR,  8'h00, 6'd0,  2'd0, 14'd0,     3'd0);
        wait_drained();

        // long output hold while requests keep coming: the queue fills up
        rx_hold_len = HOLD_CYCLES;
        tx_idle_en  = 1'b0;
        repeat (12) send_random_request(counted);
        wait_drained();
        tx_idle_en = 1'b1;

        repeat (4) begin
            random_phase(MAIN_ITEMS / 4);
            rx_idle_en = $urandom_range(0, 3) != 0;
            tx_idle_en = $urandom_range(0, 3) != 0;
        end

        // quiet tail: full rate on both sides
        rx_idle_en = 1'b0;
        tx_idle_en = 1'b0;
        random_phase(TAIL_ITEMS);

        wait_drained();
        repeat (END_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("** char_lcd_4bit_write_sequencer: PASSED **");
        end else begin
            $display("** char_lcd_4bit_write_sequencer: FAILED **");
        end
        $finish;
    end

endmodule

FILE: char_lcd_4bit_write_sequencer.f
hw/rtl/lcdws_pkg.sv
hw/rtl/lcdws_front.sv
hw/rtl/lcdws_queue.sv
hw/rtl/lcdws_back.sv
hw/rtl/char_lcd_4bit_write_sequencer.sv
tb/tb_char_lcd_4bit_write_sequencer.sv
